// ----- rtl/core/isort_pkg.sv -----
// isort_pkg: shared widths, defaults and the cell control struct
// of the integer sorter; used by isort_cell and integer_sorter
// no dependencies
package isort_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 64;

    typedef logic signed [DATA_W-1:0] data_t;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert the broadcast item value
        logic pop;   // shift the chain one place toward cell 0
    } cell_ctl_t;

endpackage

// ----- rtl/core/isort_cell.sv -----
// isort_cell: one slot of the sorting chain, holds one value and a valid bit
// depends on isort_pkg
module isort_cell
    import isort_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  data_t     ins_value,
    input  logic      left_gt,
    input  data_t     left_value,
    input  logic      left_valid,
    input  data_t     right_value,
    input  logic      right_valid,
    output logic      gt,
    output data_t     value,
    output logic      valid
);

    data_t value_reg, value_next;
    logic  valid_reg, valid_next;

    // empty slot acts as plus infinity
    assign gt = !valid_reg || (value_reg > ins_value);

    // pop takes the right neighbour's value; insert: larger values move one place up, the boundary cell takes the item
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.pop) begin
            value_next = right_value;
            valid_next = right_valid;
        end else if (ctl.ins && gt) begin
            if (left_gt) begin
                value_next = left_value;
                valid_next = left_valid;
            end else begin
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ----- rtl/core/integer_sorter.sv -----
// integer_sorter: top level, a chain of isort_cell slots kept in ascending order
// depends on isort_pkg and isort_cell
//
//  channel | direction | ports
//  --------+-----------+-------------------------------------------------
//  s_      | in        | s_valid s_ready s_value s_last
//  m_      | out       | m_valid m_ready m_sorted_value m_final_res m_overflow
//
// an accepted item is inserted, or dropped if the chain is full; on each insert the whole
// chain compares against the broadcast value and the larger part moves up one cell
// after the item marked last, the chain shifts out through cell 0, one item per
// cycle while m_ready is high; no input item is taken until the last result leaves
// synchronous active-low reset empties the chain; no clearing pass is needed
// a stalled result holds in cell 0 until taken
module integer_sorter
    import isort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  data_t s_value,
    input  logic  s_last,
    output logic  m_valid,
    input  logic  m_ready,
    output data_t m_sorted_value,
    output logic  m_final_res,
    output logic  m_overflow
);

    data_t      cell_value [DEPTH];
    logic       cell_valid [DEPTH];
    logic       cell_gt    [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    cell_ctl_t  ctl;
    logic       draining_reg, draining_next;
    logic       dropped_reg, dropped_next;
    logic       full;
    logic       in_acc, out_acc;

    assign full    = cell_valid[DEPTH-1];
    assign s_ready = !draining_reg;
    assign in_acc  = s_valid && s_ready;
    assign m_valid = draining_reg && cell_valid[0];
    assign out_acc = m_valid && m_ready;

    assign ctl.ins = in_acc && !full;
    assign ctl.pop = out_acc;

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  l_gt, l_valid, r_valid;
        data_t l_value, r_value;

        if (i == 0) begin : g_first
            assign l_gt    = 1'b0;
            assign l_value = '0;
            assign l_valid = 1'b0;
        end else begin : g_mid
            assign l_gt    = cell_gt[i-1];
            assign l_value = cell_value[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH-1) begin : g_end
            assign r_value = '0;
            assign r_valid = 1'b0;
        end else begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
        end

        isort_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .ins_value   (s_value),
            .left_gt     (l_gt),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .right_value (r_value),
            .right_valid (r_valid),
            .gt          (cell_gt[i]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i])
        );

        assign valid_vec[i] = cell_valid[i];
    end

    // result value comes straight from cell 0, the final flag from cell 1 being empty
    assign m_sorted_value = cell_value[0];
    assign m_final_res    = !cell_valid[1];
    assign m_overflow     = dropped_reg;

    // block control: collect, then drain; also records dropped items for m_overflow
    always_comb begin
        draining_next = draining_reg;
        dropped_next  = dropped_reg;
        if (in_acc) begin
            if (full) begin
                dropped_next = 1'b1;
            end
            if (s_last) begin
                draining_next = 1'b1;
            end
        end
        if (out_acc && m_final_res) begin
            draining_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draining_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end else begin
            draining_reg <= draining_next;
            dropped_reg  <= dropped_next;
        end
    end

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, valid_vec} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("occupied cells not contiguous from cell 0");

    // closing item always yields a result next cycle
    a_close_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_last |=> m_valid)
        else $error("closing item left no result");

    // after the final result the chain is empty and input reopens
    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_final_res |=> s_ready && !cell_valid[0] && !dropped_reg)
        else $error("chain not empty after final result");

    // no result while collecting
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("result shown while collecting");

endmodule
